// ----- hw/rtl/multiply_blend_with_alpha_unit_macros.svh -----
// assertion helpers, sampled on clk and disabled while rst_n is low
`ifndef MULTIPLY_BLEND_WITH_ALPHA_UNIT_MACROS_SVH
`define MULTIPLY_BLEND_WITH_ALPHA_UNIT_MACROS_SVH

// same-cycle implication
`define MBWA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MBWA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/mbwa_pkg.sv -----
package mbwa_pkg;

  localparam int CODE_W    = 8;
  localparam int NCH       = 3;
  localparam int K_W       = 2 * CODE_W;
  localparam int DEN_W     = 24;
  localparam int NUM_W     = 32;
  localparam int QUO_W     = CODE_W;
  localparam int DIV_STEPS = QUO_W;

  localparam logic [CODE_W-1:0] FULL_CODE = 8'd255;
  localparam logic [K_W-1:0]    FULL_SQ   = 16'd65025;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MODE = 2'd1;

  localparam logic [CODE_W-1:0] OPACITY_RST    = 8'd255;
  localparam logic              ALPHA_MODE_RST = 1'b0;

  typedef logic [CODE_W-1:0] code_t;
  typedef code_t [NCH-1:0] pix_t;

  typedef struct packed {
    logic [NCH-1:0][NUM_W-1:0] rem;
    logic [DEN_W-1:0]          den;
    pix_t                      quo;
    pix_t                      base;
    logic                      pass;
  } div_t;

endpackage

// ----- hw/rtl/mbwa_front.sv -----
module mbwa_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbwa_pkg::code_t      opacity,
  input  logic                 alpha_mode,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mbwa_pkg::pix_t       base,
  input  mbwa_pkg::code_t      base_alpha,
  input  mbwa_pkg::pix_t       layer,
  input  mbwa_pkg::code_t      layer_alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mbwa_pkg::div_t       out_data
);

  localparam int K_W   = mbwa_pkg::K_W;
  localparam int DEN_W = mbwa_pkg::DEN_W;
  localparam int NUM_W = mbwa_pkg::NUM_W;
  localparam int NCH   = mbwa_pkg::NCH;

  logic [3:0] v_r;
  logic [3:0] rdy;

  // stage 1: effective alpha times opacity
  mbwa_pkg::code_t a_sel, la_sel, m_sel;
  logic [K_W-1:0]  k_nxt;
  logic [K_W-1:0]  k1_r;
  mbwa_pkg::code_t a1_r;
  mbwa_pkg::pix_t  b1_r, c1_r;

  // stage 2: partial products
  logic [NCH-1:0][DEN_W-1:0] ck_nxt, ck2_r;
  logic [DEN_W-1:0]          ak_nxt, qa_nxt, qk_nxt;
  logic [DEN_W-1:0]          ak2_r, qa2_r, qk2_r;
  logic                      pass2_r;
  mbwa_pkg::pix_t            b2_r;

  // stage 3: sums
  logic [NCH-1:0][DEN_W-1:0] inner_nxt, inner3_r;
  logic [DEN_W-1:0]          den_nxt, den3_r;
  logic                      pass3_r;
  mbwa_pkg::pix_t            b3_r;

  // stage 4: numerator
  mbwa_pkg::div_t            d4_nxt, d4_r;

  assign rdy[3]   = !v_r[3] || out_ready;
  assign rdy[2]   = !v_r[2] || rdy[3];
  assign rdy[1]   = !v_r[1] || rdy[2];
  assign rdy[0]   = !v_r[0] || rdy[1];
  assign in_ready = rdy[0];

  always_comb begin
    a_sel  = alpha_mode ? base_alpha  : mbwa_pkg::FULL_CODE;
    la_sel = alpha_mode ? layer_alpha : mbwa_pkg::FULL_CODE;
    m_sel  = (a_sel < la_sel) ? a_sel : la_sel;
    k_nxt  = K_W'(m_sel) * K_W'(opacity);
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      ck_nxt[i] = DEN_W'(c1_r[i]) * DEN_W'(k1_r);
    end
    ak_nxt = DEN_W'(a1_r) * DEN_W'(mbwa_pkg::FULL_SQ - k1_r);
    qa_nxt = DEN_W'(a1_r) * DEN_W'(mbwa_pkg::FULL_SQ);
    qk_nxt = DEN_W'(mbwa_pkg::FULL_CODE - a1_r) * DEN_W'(k1_r);
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      inner_nxt[i] = DEN_W'(ck2_r[i] + ak2_r);
    end
    den_nxt = DEN_W'(qa2_r + qk2_r);
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      d4_nxt.rem[i] = NUM_W'(b3_r[i]) * NUM_W'(inner3_r[i]);
    end
    d4_nxt.den  = den3_r;
    d4_nxt.quo  = '0;
    d4_nxt.base = b3_r;
    d4_nxt.pass = pass3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_valid;
      if (rdy[1]) v_r[1] <= v_r[0];
      if (rdy[2]) v_r[2] <= v_r[1];
      if (rdy[3]) v_r[3] <= v_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      k1_r <= k_nxt;
      a1_r <= a_sel;
      b1_r <= base;
      c1_r <= layer;
    end
    if (rdy[1] && v_r[0]) begin
      ck2_r   <= ck_nxt;
      ak2_r   <= ak_nxt;
      qa2_r   <= qa_nxt;
      qk2_r   <= qk_nxt;
      pass2_r <= (k1_r == '0);
      b2_r    <= b1_r;
    end
    if (rdy[2] && v_r[1]) begin
      inner3_r <= inner_nxt;
      den3_r   <= den_nxt;
      pass3_r  <= pass2_r;
      b3_r     <= b2_r;
    end
    if (rdy[3] && v_r[2]) begin
      d4_r <= d4_nxt;
    end
  end

  assign out_valid = v_r[3];
  assign out_data  = d4_r;

endmodule

// ----- hw/rtl/mbwa_div_step.sv -----
module mbwa_div_step #(
  parameter int BIT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mbwa_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mbwa_pkg::div_t  out_data
);

  localparam int NUM_W = mbwa_pkg::NUM_W;
  localparam int SUB_W = NUM_W + 1;
  localparam int NCH   = mbwa_pkg::NCH;

  logic                      valid_r;
  mbwa_pkg::div_t            data_r, data_nxt;
  logic [SUB_W-1:0]          shifted;
  logic [NCH-1:0][SUB_W-1:0] trial;

  assign in_ready = !valid_r || out_ready;

  // one restoring quotient bit per channel
  always_comb begin
    data_nxt = in_data;
    shifted  = SUB_W'(in_data.den) << BIT;
    for (int i = 0; i < NCH; i++) begin
      trial[i] = {1'b0, in_data.rem[i]} - shifted;
      if (!trial[i][SUB_W-1]) begin
        data_nxt.rem[i]      = trial[i][NUM_W-1:0];
        data_nxt.quo[i][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ----- hw/rtl/mbwa_round.sv -----
`include "multiply_blend_with_alpha_unit_macros.svh"

module mbwa_round (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  mbwa_pkg::div_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output mbwa_pkg::pix_t  out_pix
);

  localparam int DEN_W  = mbwa_pkg::DEN_W;
  localparam int NUM_W  = mbwa_pkg::NUM_W;
  localparam int CODE_W = mbwa_pkg::CODE_W;
  localparam int NCH    = mbwa_pkg::NCH;

  logic                        out_valid_r;
  mbwa_pkg::pix_t              res_r, base_r, res_nxt;
  logic [NCH-1:0][DEN_W:0]     twice;
  logic [NCH-1:0]              up;
  logic [NCH-1:0][CODE_W:0]    sum;
  logic                        rem_ok, no_ovf, res_le;

  assign in_ready = !out_valid_r || out_ready;

  // round half to even and clamp to 255, pass base through when effective alpha times opacity is zero
  always_comb begin
    rem_ok = 1'b1;
    no_ovf = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      twice[i] = {in_data.rem[i][DEN_W-1:0], 1'b0};
      up[i]    = (twice[i] > {1'b0, in_data.den}) ||
                 ((twice[i] == {1'b0, in_data.den}) && in_data.quo[i][0]);
      sum[i]   = {1'b0, in_data.quo[i]} + (CODE_W+1)'(up[i]);
      if (in_data.pass) begin
        res_nxt[i] = in_data.base[i];
      end else if (sum[i][CODE_W]) begin
        res_nxt[i] = mbwa_pkg::FULL_CODE;
      end else begin
        res_nxt[i] = sum[i][CODE_W-1:0];
      end
      rem_ok = rem_ok && (in_data.rem[i] < NUM_W'(in_data.den));
      no_ovf = no_ovf && !sum[i][CODE_W];
    end
  end

  always_comb begin
    res_le = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      res_le = res_le && (res_r[i] <= base_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      res_r  <= res_nxt;
      base_r <= in_data.base;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pix   = res_r;

  `MBWA_ASSERT_NOW(a_rem_below_den, in_valid && !in_data.pass, rem_ok, "remainder not below divisor")
  `MBWA_ASSERT_NOW(a_round_no_ovf, in_valid && !in_data.pass, no_ovf, "rounded quotient overflow")
  `MBWA_ASSERT_NOW(a_res_le_base, out_valid_r, res_le, "blended channel above base channel")

endmodule

// ----- hw/rtl/multiply_blend_with_alpha_unit.sv -----
// stages: 4 product stages, 8 divider stages at one quotient bit each, 1 rounding stage
// throughput: one request per cycle while the output accepts; the 13-stage pipeline and per-stage ready
// let bubbles close up under output stall
// reset (synchronous, rst_n low): pipeline emptied, opacity 255, three-channel mode
`include "multiply_blend_with_alpha_unit_macros.svh"

module multiply_blend_with_alpha_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbwa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbwa_pkg::CODE_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_base_blue,
  input  logic [7:0]                          in_base_green,
  input  logic [7:0]                          in_base_red,
  input  logic [7:0]                          in_base_alpha,
  input  logic [7:0]                          in_layer_blue,
  input  logic [7:0]                          in_layer_green,
  input  logic [7:0]                          in_layer_red,
  input  logic [7:0]                          in_layer_alpha,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_blue,
  output logic [7:0]                          out_green,
  output logic [7:0]                          out_red
);

  localparam int STEPS = mbwa_pkg::DIV_STEPS;

  mbwa_pkg::code_t  opacity_r;
  logic             alpha_mode_r;
  logic             cfg_wr;

  mbwa_pkg::pix_t   base_pix, layer_pix, res_pix;
  mbwa_pkg::div_t   div_d   [0:STEPS];
  logic [STEPS:0]   div_v;
  logic [STEPS:0]   div_rdy;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opacity_r    <= mbwa_pkg::OPACITY_RST;
      alpha_mode_r <= mbwa_pkg::ALPHA_MODE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        mbwa_pkg::CFG_OPACITY:    opacity_r    <= cfg_data;
        mbwa_pkg::CFG_ALPHA_MODE: alpha_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign base_pix  = {in_base_red, in_base_green, in_base_blue};
  assign layer_pix = {in_layer_red, in_layer_green, in_layer_blue};

  mbwa_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .opacity     (opacity_r),
    .alpha_mode  (alpha_mode_r),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .base        (base_pix),
    .base_alpha  (in_base_alpha),
    .layer       (layer_pix),
    .layer_alpha (in_layer_alpha),
    .out_valid   (div_v[0]),
    .out_ready   (div_rdy[0]),
    .out_data    (div_d[0])
  );

  for (genvar j = 0; j < STEPS; j++) begin : g_div
    mbwa_div_step #(
      .BIT (STEPS - 1 - j)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[j]),
      .in_ready  (div_rdy[j]),
      .in_data   (div_d[j]),
      .out_valid (div_v[j+1]),
      .out_ready (div_rdy[j+1]),
      .out_data  (div_d[j+1])
    );
  end

  mbwa_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (div_v[STEPS]),
    .in_ready  (div_rdy[STEPS]),
    .in_data   (div_d[STEPS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (res_pix)
  );

  assign out_blue  = res_pix[0];
  assign out_green = res_pix[1];
  assign out_red   = res_pix[2];

  `MBWA_ASSERT_NXT(a_cfg_opacity, cfg_wr && (cfg_index == mbwa_pkg::CFG_OPACITY), opacity_r == $past(cfg_data), "opacity write lost")
  `MBWA_ASSERT_NXT(a_cfg_mode, cfg_wr && (cfg_index == mbwa_pkg::CFG_ALPHA_MODE), alpha_mode_r == $past(cfg_data[0]), "alpha mode write lost")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import mbwa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    code_t base_blue;
    code_t base_green;
    code_t base_red;
    code_t base_alpha;
    code_t layer_blue;
    code_t layer_green;
    code_t layer_red;
    code_t layer_alpha;
  } pixel_req_t;

  typedef struct packed {
    code_t blue;
    code_t green;
    code_t red;
  } rgb_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  code_t cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  code_t in_base_blue = '0;
  code_t in_base_green = '0;
  code_t in_base_red = '0;
  code_t in_base_alpha = '0;
  code_t in_layer_blue = '0;
  code_t in_layer_green = '0;
  code_t in_layer_red = '0;
  code_t in_layer_alpha = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  code_t out_blue;
  code_t out_green;
  code_t out_red;

  code_t opacity_reg = OPACITY_RST;
  logic alpha_mode_reg = ALPHA_MODE_RST;

  rgb_t expected_rgb_q[$];
  int send_idle_pct = 13;
  int recv_idle_pct = 83;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int setting_count = 0;
  int idle_cycles = 0;

  multiply_blend_with_alpha_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_base_blue(in_base_blue),
    .in_base_green(in_base_green),
    .in_base_red(in_base_red),
    .in_base_alpha(in_base_alpha),
    .in_layer_blue(in_layer_blue),
    .in_layer_green(in_layer_green),
    .in_layer_red(in_layer_red),
    .in_layer_alpha(in_layer_alpha),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_blue(out_blue),
    .out_green(out_green),
    .out_red(out_red)
  );

  always #6 clk = ~clk;

  function automatic code_t blend_code(input code_t b, input code_t c, input code_t a,
                                       input logic [15:0] k);
    logic [63:0] bb, cc, aa, kk, num, den, quo, rem;
    bb = 64'(b);
    cc = 64'(c);
    aa = 64'(a);
    kk = 64'(k);
    if (kk == 0) return b;
    num = bb * (cc * kk + aa * (64'(FULL_SQ) - kk));
    den = aa * 64'(FULL_SQ) + (64'(FULL_CODE) - aa) * kk;
    if (den == 0) return b;
    quo = num / den;
    rem = num % den;
    if ((2 * rem > den) || ((2 * rem == den) && quo[0])) quo = quo + 1;
    if (quo > 64'(FULL_CODE)) quo = 64'(FULL_CODE);
    return quo[CODE_W-1:0];
  endfunction

  function automatic rgb_t blend_pixel(input pixel_req_t p);
    code_t a, la, m;
    logic [15:0] k;
    rgb_t r;
    a = alpha_mode_reg ? p.base_alpha : FULL_CODE;
    la = alpha_mode_reg ? p.layer_alpha : FULL_CODE;
    m = (a < la) ? a : la;
    k = 16'(m) * 16'(opacity_reg);
    r.blue = blend_code(p.base_blue, p.layer_blue, a, k);
    r.green = blend_code(p.base_green, p.layer_green, a, k);
    r.red = blend_code(p.base_red, p.layer_red, a, k);
    return r;
  endfunction

  function automatic code_t pick_alpha();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic pixel_req_t random_pixel();
    pixel_req_t p;
    int kind;
    p = {$urandom, $urandom};
    kind = $urandom_range(9);
    if (kind == 6) begin
      p.base_alpha = pick_alpha();
      p.layer_alpha = pick_alpha();
    end else if (kind == 7) begin
      p.layer_alpha = p.base_alpha;
    end else if (kind == 8) begin
      p.base_blue = pick_alpha();
      p.base_green = pick_alpha();
      p.base_red = pick_alpha();
    end else if (kind == 9) begin
      p.layer_blue = pick_alpha();
      p.layer_green = pick_alpha();
      p.layer_red = pick_alpha();
    end
    return p;
  endfunction

  function automatic pixel_req_t make_pixel(input code_t bb, bg, br, ba, lb, lg, lr, la);
    pixel_req_t p;
    p = {bb, bg, br, ba, lb, lg, lr, la};
    return p;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    rgb_t exp_rgb;
    rgb_t got_rgb;
    if (rst_n && out_valid && out_ready) begin
      got_rgb = {out_blue, out_green, out_red};
      if (expected_rgb_q.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("unexpected result b/g/r %h %h %h", out_blue, out_green, out_red);
      end else begin
        exp_rgb = expected_rgb_q.pop_front();
        checked_count++;
        if (got_rgb.blue !== exp_rgb.blue || got_rgb.green !== exp_rgb.green ||
            got_rgb.red !== exp_rgb.red) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("mismatch at result %0d: expected b/g/r %h %h %h, got %h %h %h",
                     checked_count, exp_rgb.blue, exp_rgb.green, exp_rgb.red,
                     got_rgb.blue, got_rgb.green, got_rgb.red);
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_rgb_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input pixel_req_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_base_blue <= p.base_blue;
    in_base_green <= p.base_green;
    in_base_red <= p.base_red;
    in_base_alpha <= p.base_alpha;
    in_layer_blue <= p.layer_blue;
    in_layer_green <= p.layer_green;
    in_layer_red <= p.layer_red;
    in_layer_alpha <= p.layer_alpha;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_rgb_q.push_back(blend_pixel(p));
    sent_count++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input code_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_OPACITY)
      opacity_reg = data;
    else if (idx == CFG_ALPHA_MODE)
      alpha_mode_reg = data[0];
    setting_count++;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_request(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff));
    send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_request(make_pixel(8'h00, 8'h80, 8'hff, 8'h00, 8'hff, 8'h80, 8'h01, 8'h00));
    drain_results();
  endtask

  task automatic test_register_writes();
    cfg_write(CFG_SPARE_A, 8'h00);
    cfg_write(CFG_SPARE_B, 8'h01);
    send_request(make_pixel(8'hc8, 8'h64, 8'h32, 8'h00, 8'h40, 8'h80, 8'hc0, 8'h00));
    drain_results();
    cfg_write(CFG_ALPHA_MODE, 8'h01);
    send_request(make_pixel(8'hc8, 8'h64, 8'h32, 8'h80, 8'h40, 8'h80, 8'hc0, 8'hc8));
    drain_results();
    cfg_write(CFG_ALPHA_MODE, 8'hfe);
    send_request(make_pixel(8'hc8, 8'h64, 8'h32, 8'h00, 8'h40, 8'h80, 8'hc0, 8'h00));
    drain_results();
    cfg_write(CFG_OPACITY, 8'h00);
    send_request(make_pixel(8'hc8, 8'h64, 8'h32, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff));
    drain_results();
    cfg_write(CFG_OPACITY, 8'h01);
    send_request(make_pixel(8'hff, 8'h7f, 8'h01, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff));
    drain_results();
  endtask

  task automatic test_alpha_cases();
    cfg_write(CFG_ALPHA_MODE, 8'h01);
    cfg_write(CFG_OPACITY, 8'hff);
    send_request(make_pixel(8'h90, 8'h50, 8'hf0, 8'h00, 8'h10, 8'h20, 8'h30, 8'hff));
    send_request(make_pixel(8'h90, 8'h50, 8'hf0, 8'hff, 8'h10, 8'h20, 8'h30, 8'h00));
    send_request(make_pixel(8'h90, 8'h50, 8'hf0, 8'hff, 8'h10, 8'h20, 8'h30, 8'hff));
    send_request(make_pixel(8'h90, 8'h50, 8'hf0, 8'hff, 8'h10, 8'h20, 8'h30, 8'h01));
    send_request(make_pixel(8'h90, 8'h50, 8'hf0, 8'h01, 8'h10, 8'h20, 8'h30, 8'hff));
    send_request(make_pixel(8'hff, 8'hff, 8'hff, 8'h7f, 8'h00, 8'hff, 8'h80, 8'hfe));
    drain_results();
  endtask

  task automatic test_rounding_ties();
    // base and layer alpha 2: halfway quotients round up or down to the even code
    send_request(make_pixel(8'd2, 8'd254, 8'd127, 8'd2, 8'd128, 8'd254, 8'd253, 8'd2));
    send_request(make_pixel(8'd254, 8'd127, 8'd2, 8'd2, 8'd254, 8'd253, 8'd128, 8'd2));
    drain_results();
    cfg_write(CFG_OPACITY, 8'd153);
    send_request(make_pixel(8'd113, 8'd3, 8'd60, 8'd2, 8'd252, 8'd142, 8'd60, 8'd2));
    drain_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int n_items);
    int per_setting;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    per_setting = n_items / 5;
    for (int s = 0; s < 5; s++) begin
      drain_results();
      case (s)
        0: begin
          cfg_write(CFG_OPACITY, 8'hff);
          cfg_write(CFG_ALPHA_MODE, 8'h01);
        end
        1: begin
          cfg_write(CFG_OPACITY, 8'h00);
          cfg_write(CFG_ALPHA_MODE, code_t'($urandom_range(1)));
        end
        2: begin
          cfg_write(CFG_OPACITY, code_t'($urandom_range(1, 254)));
          cfg_write(CFG_ALPHA_MODE, 8'h00);
        end
        default: begin
          cfg_write(CFG_OPACITY, code_t'($urandom_range(255)));
          cfg_write(CFG_ALPHA_MODE, code_t'($urandom));
        end
      endcase
      for (int i = 0; i < per_setting; i++) begin
        // hold off until the pipeline has emptied
        if (s == 0 && i == per_setting / 2) drain_results();
        send_request(random_pixel());
      end
    end
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_register_writes();
    test_alpha_cases();
    test_rounding_ties();
    test_random_traffic(13, 83, 633);
    test_random_traffic(83, 13, 633);
    test_random_traffic(0, 0, 634);
    drain_results();
    $display("covered %0d pixel requests and %0d checked results across %0d register writes",
             sent_count, checked_count, setting_count);
    $display("mismatches or unexpected results: %0d", error_count);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
